>>> hdl/pbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbx_pkg
// Shared types, register indexes and pixel extraction for the bitmap expander.
// ----------------------------------------------------------------------------
package pbx_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_DEPTH_CODE  = 3'd0;
  localparam logic [2:0] REG_DRAW_FLAGS  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_WIDTH_PIX   = 3'd4;
  localparam logic [2:0] REG_HEIGHT_ROWS = 3'd5;
  localparam logic [2:0] REG_FIRST_OFS   = 3'd6;
  localparam logic [2:0] REG_ROW_STRIDE  = 3'd7;

  // depth codes
  localparam logic [2:0] DC_1BPP  = 3'd0;
  localparam logic [2:0] DC_2BPP  = 3'd1;
  localparam logic [2:0] DC_4BPP  = 3'd2;
  localparam logic [2:0] DC_8BPP  = 3'd3;
  localparam logic [2:0] DC_16BPP = 3'd4;

  // input word kinds
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_SOURCE  = 1'b1;

  localparam int unsigned BYTE_COUNT_MAX = 4095;

  typedef logic [15:0] pix_t;

  // pixels per source byte (16 bpp: one per word)
  function automatic logic [3:0] pix_per_byte(input logic [2:0] dc);
    logic [3:0] n;
    unique case (dc)
      DC_1BPP: n = 4'd8;
      DC_2BPP: n = 4'd4;
      DC_4BPP: n = 4'd2;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // raw pixel at position p, most significant pixel first
  function automatic pix_t pix_extract(input logic [15:0] word, input logic [2:0] dc,
                                       input logic [2:0] p);
    logic [7:0] b;
    logic [2:0] sh;
    pix_t       v;
    b  = word[7:0];
    sh = 3'd0;
    unique case (dc)
      DC_1BPP: begin
        sh = 3'd7 - p;
        v  = {15'd0, b[sh]};
      end
      DC_2BPP: begin
        sh = {2'd3 - p[1:0], 1'b0};
        v  = {14'd0, 2'(b >> sh)};
      end
      DC_4BPP: begin
        sh = {~p[0], 2'b00};
        v  = {12'd0, 4'(b >> sh)};
      end
      DC_8BPP: v = {8'd0, b};
      default: v = word;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/pbx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/packed_bitmap_pixel_expander_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bitmap_pixel_expander_core
// Unpacks 1/2/4/8/16 bpp bitmap rows into (x, y, color) pixel writes.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects palette write (0) or source word (1); in_tdata
// carries the palette slot and the data value. Output stream: one word per
// pixel write; out_tlast marks the last pixel of an input word and out_tuser
// marks the last pixel of the whole bitmap.
// The palette is a RAM with registered read; its read happens in the same
// cycle the pixel is expanded, so a pixel passes the held word register and
// then the output register before it is visible on the output.
// Throughput: one pixel write per cycle unless the output stalls. A source
// word takes one step per pixel position it walks: 8, 4, 2 or 1 positions
// per byte, less the row skip on the first byte of a row, cut short once the
// row width is drawn, and at least one. A transparent pixel still takes its
// step; a palette write or a padding word takes a single step. The next word
// is taken in the cycle the last position of the held word steps, so words
// follow back to back. Reset clears counters, config and valid flags; palette
// contents are undefined until written. When out_tready is low the output
// register holds and the expander stalls on pixel words; palette writes still
// proceed. Configuration is written through cfg_* while the block is idle.
// ----------------------------------------------------------------------------
module packed_bitmap_pixel_expander_core
  import pbx_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int COORD_BITS    = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] palette_slot, [23:8] data_value
  input  logic        in_tuser,   // cmd
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [((2*COORD_BITS+16+7)/8)*8-1:0] out_tdata, // pixel_x, pixel_y, pixel_color
  output logic        out_tlast,  // last_of_item
  output logic        out_tuser   // bitmap_done
);

  localparam int OUT_W     = ((2*COORD_BITS + 16 + 7) / 8) * 8;
  localparam int ADDR_W    = $clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2);
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  // configuration registers
  logic [2:0]  depth_code_r;
  logic [1:0]  draw_flags_r;
  logic [9:0]  origin_x_r;
  logic [9:0]  origin_y_r;
  logic [10:0] width_pix_r;
  logic [10:0] height_rows_r;
  logic [2:0]  first_ofs_r;
  logic [11:0] row_stride_r;

  // held input word
  logic        a_valid_r;
  logic        a_cmd_r;
  logic [7:0]  a_slot_r;
  logic [15:0] a_word_r;
  logic        a_first_r;
  logic [2:0]  a_pos_r;

  // counters
  logic [10:0] col_r;
  logic [10:0] row_r;
  logic [11:0] byte_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [15:0]           out_raw_r;
  logic                  out_pal_r;
  logic                  out_inrange_r;
  logic                  out_last_r;
  logic                  out_done_r;

  logic [15:0] pal_rdata;

  // expander logic
  logic [2:0]  dc;
  logic [3:0]  ppb;
  logic        transp;
  logic        use_pal;
  logic [2:0]  rowskip;
  logic [2:0]  pos;
  pix_t        pix [8];
  logic [7:0]  vis;
  logic [11:0] rem;
  logic [3:0]  rel;
  logic        active;
  logic        finish;
  logic        step;
  logic        a_done;
  logic        b_ready;
  logic        emit;
  logic        later_emit;
  logic        row_last;
  logic        done_item;
  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic [10:0] col_after;
  logic [12:0] byte_sum;
  logic [11:0] byte_nxt;
  logic [11:0] row_inc;
  logic        pal_we;
  logic        slot_ok;
  logic        raw_ok;
  logic [15:0] color;

  always_comb begin
    dc      = (depth_code_r > DC_16BPP) ? DC_16BPP : depth_code_r;
    ppb     = pix_per_byte(dc);
    transp  = draw_flags_r[0];
    use_pal = (dc == DC_1BPP) || ((dc != DC_16BPP) && draw_flags_r[1]);
    rowskip = first_ofs_r & 3'(ppb - 4'd1);
    pos     = a_first_r ? ((byte_r == 12'd0) ? rowskip : 3'd0) : a_pos_r;

    for (int p = 0; p < 8; p++) begin
      pix[p] = pix_extract(a_word_r, dc, 3'(p));
      vis[p] = (4'(p) < ppb) && !(transp && (pix[p] == 16'd0));
    end

    active   = col_r < width_pix_r;
    rem      = 12'(width_pix_r) - 12'(col_r);
    finish   = !active || ({1'b0, pos} + 4'd1 >= ppb) || (12'(col_r) + 12'd1 >= 12'(width_pix_r));
    b_ready  = !out_valid_r || out_tready;
    step     = a_valid_r && ((a_cmd_r == CMD_PALETTE) || b_ready);
    a_done   = step && ((a_cmd_r == CMD_PALETTE) || finish);
    emit     = step && (a_cmd_r == CMD_SOURCE) && active && vis[pos];

    // look ahead for a later visible pixel in this word
    later_emit = 1'b0;
    for (int p = 0; p < 8; p++) begin
      rel = 4'(p) - {1'b0, pos};
      if ((3'(p) > pos) && (12'(rel) < rem) && vis[p]) begin
        later_emit = 1'b1;
      end
    end

    row_inc   = 12'(row_r) + 12'd1;
    row_last  = row_inc >= 12'(height_rows_r);
    done_item = row_last && (rem <= 12'(ppb - {1'b0, pos}));

    x_sum = 17'(origin_x_r) + 17'(rowskip) + 17'(col_r);
    y_sum = 17'(origin_y_r) + 17'(row_r);

    col_after = active ? (col_r + 11'd1) : col_r;
    byte_sum  = 13'(byte_r) + ((dc == DC_16BPP) ? 13'd2 : 13'd1);
    byte_nxt  = (byte_sum > 13'(BYTE_COUNT_MAX)) ? 12'(BYTE_COUNT_MAX) : byte_sum[11:0];

    slot_ok = {1'b0, a_slot_r} < 9'(PALETTE_DEPTH);
    pal_we  = step && (a_cmd_r == CMD_PALETTE) && slot_ok;
    raw_ok  = pix[pos] < 16'(PALETTE_DEPTH);
  end

  assign in_tready = !a_valid_r || a_done;

  pbx_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (a_slot_r[ADDR_W-1:0]),
    .wdata (a_word_r),
    .re    (emit),
    .raddr (pix[pos][ADDR_W-1:0]),
    .rdata (pal_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_code_r  <= DC_1BPP;
      draw_flags_r  <= 2'd0;
      origin_x_r    <= 10'd0;
      origin_y_r    <= 10'd0;
      width_pix_r   <= 11'd1;
      height_rows_r <= 11'd1;
      first_ofs_r   <= 3'd0;
      row_stride_r  <= 12'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DEPTH_CODE:  depth_code_r  <= cfg_wdata[2:0];
        REG_DRAW_FLAGS:  draw_flags_r  <= cfg_wdata[1:0];
        REG_ORIGIN_X:    origin_x_r    <= cfg_wdata[9:0];
        REG_ORIGIN_Y:    origin_y_r    <= cfg_wdata[9:0];
        REG_WIDTH_PIX:   width_pix_r   <= cfg_wdata[10:0];
        REG_HEIGHT_ROWS: height_rows_r <= cfg_wdata[10:0];
        REG_FIRST_OFS:   first_ofs_r   <= cfg_wdata[2:0];
        REG_ROW_STRIDE:  row_stride_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // held word and pixel position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_first_r <= 1'b0;
      a_pos_r   <= 3'd0;
    end else if (in_tvalid && in_tready) begin
      a_valid_r <= 1'b1;
      a_first_r <= 1'b1;
    end else if (a_done) begin
      a_valid_r <= 1'b0;
    end else if (step) begin
      // advance to the next pixel of this word
      a_first_r <= 1'b0;
      a_pos_r   <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_cmd_r  <= in_tuser;
      a_slot_r <= in_tdata[7:0];
      a_word_r <= in_tdata[23:8];
    end
  end

  // column, row and byte counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= 11'd0;
      row_r  <= 11'd0;
      byte_r <= 12'd0;
    end else if (step && (a_cmd_r == CMD_SOURCE)) begin
      if (finish) begin
        if ((byte_nxt >= row_stride_r) && (col_after >= width_pix_r)) begin
          // row end: wrap after the last row
          byte_r <= 12'd0;
          col_r  <= 11'd0;
          row_r  <= row_last ? 11'd0 : row_inc[10:0];
        end else begin
          byte_r <= byte_nxt;
          col_r  <= col_after;
        end
      end else begin
        col_r <= col_after;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r       <= (x_sum > 17'(COORD_MAX)) ? COORD_BITS'(COORD_MAX) : x_sum[COORD_BITS-1:0];
      out_y_r       <= (y_sum > 17'(COORD_MAX)) ? COORD_BITS'(COORD_MAX) : y_sum[COORD_BITS-1:0];
      out_raw_r     <= pix[pos];
      out_pal_r     <= use_pal;
      out_inrange_r <= raw_ok;
      out_last_r    <= !later_emit;
      out_done_r    <= !later_emit && done_item;
    end
  end

  // palette data arrives with the output register
  assign color      = out_pal_r ? (out_inrange_r ? pal_rdata : 16'd0) : out_raw_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({color, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

>>> test/tb_packed_bitmap_pixel_expander_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_bitmap_pixel_expander_core
// Self-checking bench for the packed bitmap expander. The palette is loaded in
// full, a short directed set hits the depth modes, transparency, row skip,
// padding, short strides and zero width/height, then random bitmaps follow,
// mostly complete ones with a few truncated or overlong. A transaction model of the
// unpacker predicts every pixel word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_packed_bitmap_pixel_expander_core;
  import pbx_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int COORD_W        = 11;
  localparam int unsigned COORD_LIMIT = (1 << COORD_W) - 1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RAND_ITEMS     = 150;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // draw flag bits
  localparam logic [1:0] DRAW_TRANSP  = 2'b01;
  localparam logic [1:0] DRAW_PALETTE = 2'b10;
  // largest depth code; codes past 16 bpp behave as 16 bpp
  localparam logic [2:0] DC_WIDE_MAX  = 3'd7;

  typedef struct {
    logic        cmd;
    logic [7:0]  slot;
    logic [15:0] data;
    bit          drain;   // hold this word until every pixel has come out
  } src_word_t;

  typedef struct {
    logic [10:0] x;
    logic [10:0] y;
    logic [15:0] color;
    logic        last;
    logic        done;
  } pixel_t;

  typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_HOLD} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = REG_DEPTH_CODE;
  logic [11:0] cfg_wdata = 12'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'd0;
  logic        in_tuser = CMD_PALETTE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  packed_bitmap_pixel_expander_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // words waiting for the driver, pixels waiting for the output
  src_word_t   src_words[$];
  pixel_t      pix_expect[$];
  int          fail_cnt = 0;

  // shadow of the block's registers and counters
  logic [15:0] pal_mem [256];
  logic [2:0]  cfg_depth = DC_1BPP;
  logic [1:0]  cfg_flags = 2'b00;
  int unsigned cfg_ox = 0, cfg_oy = 0, cfg_width = 1, cfg_height = 1;
  int unsigned cfg_ofs = 0, cfg_stride = 1;
  int unsigned col_cnt = 0, row_cnt = 0, byte_cnt = 0;

  function automatic logic [10:0] sat_coord(input int unsigned v);
    return (v > COORD_LIMIT) ? 11'(COORD_LIMIT) : 11'(v);
  endfunction

  // unpack one accepted word into the pixels it writes
  task automatic expand_word(input logic cmd, input logic [7:0] slot,
                             input logic [15:0] data);
    int unsigned bpp, ppb, rowskip, j, raw, nb;
    logic [15:0] word;
    logic        transp, use_pal, done;
    pixel_t      px;
    pixel_t      burst[$];
    if (cmd == CMD_PALETTE) begin
      pal_mem[slot] = data;
    end else begin
      bpp     = (cfg_depth > DC_16BPP) ? 16 : (1 << cfg_depth);
      ppb     = (bpp < 16) ? 8 / bpp : 1;
      word    = (bpp < 16) ? {8'h00, data[7:0]} : data;
      transp  = (cfg_flags & DRAW_TRANSP) != 2'b00;
      use_pal = (bpp == 1) || (bpp < 16 && (cfg_flags & DRAW_PALETTE) != 2'b00);
      rowskip = cfg_ofs & (ppb - 1);
      done    = 1'b0;
      for (j = (byte_cnt == 0) ? rowskip : 0; j < ppb; j++) begin
        if (col_cnt >= cfg_width) break;
        raw = (word >> ((ppb - 1 - j) * bpp)) & ((1 << bpp) - 1);
        if (!(transp && raw == 0)) begin
          px.x     = sat_coord(cfg_ox + rowskip + col_cnt);
          px.y     = sat_coord(cfg_oy + row_cnt);
          px.color = use_pal ? pal_mem[raw[7:0]] : raw[15:0];
          px.last  = 1'b0;
          px.done  = 1'b0;
          burst.push_back(px);
        end
        if (col_cnt + 1 >= cfg_width && row_cnt + 1 >= cfg_height) done = 1'b1;
        col_cnt++;
      end
      nb = byte_cnt + ((bpp == 16) ? 2 : 1);
      byte_cnt = (nb > BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : nb;
      // row ends once the stride is consumed and the width drawn
      if (byte_cnt >= cfg_stride && col_cnt >= cfg_width) begin
        byte_cnt = 0;
        col_cnt  = 0;
        row_cnt++;
        if (row_cnt >= cfg_height || row_cnt > 2047) row_cnt = 0;
      end
      if (burst.size() > 0) begin
        burst[burst.size() - 1].last = 1'b1;
        burst[burst.size() - 1].done = done;
      end
      foreach (burst[k]) pix_expect.push_back(burst[k]);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input logic [15:0] got);
    if (got !== want[15:0]) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // sender: bursts of words with random gaps
  int tx_burst = 1;
  int tx_gap   = 0;

  always @(posedge clk) begin : driver
    src_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        tx_gap    <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (src_words.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (src_words[0].drain && (in_tvalid || pix_expect.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = src_words.pop_front();
        in_tdata  <= {nxt.data, nxt.slot};
        in_tuser  <= nxt.cmd;
        in_tvalid <= 1'b1;
        if (tx_burst <= 1) begin
          tx_burst <= $urandom_range(1, 24);
          tx_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          tx_burst <= tx_burst - 1;
        end
      end
    end
  end

  // receiver: stall pattern that switches among open, coin-flip, one-in-three and hold modes
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin : rx_pattern
    if (rx_left == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      rx_left    <= $urandom_range(4, 40);
      out_tready <= 1'b1;
    end else begin
      rx_left <= rx_left - 1;
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
        RX_THIRD: out_tready <= (rx_left % 3 == 0);
        default:  out_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : scoreboard
    pixel_t want;
    if (rst_n && in_tvalid && in_tready)
      expand_word(in_tuser, in_tdata[7:0], in_tdata[23:8]);
    if (rst_n && out_tvalid && out_tready) begin
      if (pix_expect.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d color=%0h",
               out_tdata[10:0], out_tdata[21:11], out_tdata[37:22]);
        fail_cnt++;
      end else begin
        want = pix_expect.pop_front();
        check_field("pixel_x", want.x, out_tdata[10:0]);
        check_field("pixel_y", want.y, out_tdata[21:11]);
        check_field("pixel_color", want.color, out_tdata[37:22]);
        check_field("last_of_item", want.last, out_tlast);
        check_field("bitmap_done", want.done, out_tuser);
      end
    end
  end

  task automatic push_src(input logic [15:0] data, input bit drain);
    src_word_t w;
    w.cmd   = CMD_SOURCE;
    w.slot  = 8'($urandom);
    w.data  = data;
    w.drain = drain;
    src_words.push_back(w);
  endtask

  task automatic push_pal(input logic [7:0] slot, input logic [15:0] data);
    src_word_t w;
    w.cmd   = CMD_PALETTE;
    w.slot  = slot;
    w.data  = data;
    w.drain = 1'b0;
    src_words.push_back(w);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[11:0];
    case (idx)
      REG_DEPTH_CODE:  cfg_depth  = val[2:0];
      REG_DRAW_FLAGS:  cfg_flags  = val[1:0];
      REG_ORIGIN_X:    cfg_ox     = val;
      REG_ORIGIN_Y:    cfg_oy     = val;
      REG_WIDTH_PIX:   cfg_width  = val;
      REG_HEIGHT_ROWS: cfg_height = val;
      REG_FIRST_OFS:   cfg_ofs    = val;
      REG_ROW_STRIDE:  cfg_stride = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [2:0] depth, input logic [1:0] flags,
                           input int unsigned ox, input int unsigned oy,
                           input int unsigned w, input int unsigned h,
                           input int unsigned ofs, input int unsigned stride);
    cfg_write(REG_DEPTH_CODE, depth);
    cfg_write(REG_DRAW_FLAGS, flags);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_WIDTH_PIX, w);
    cfg_write(REG_HEIGHT_ROWS, h);
    cfg_write(REG_FIRST_OFS, ofs);
    cfg_write(REG_ROW_STRIDE, stride);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // block is idle once nothing is queued, held or expected, plus its latency
  task automatic wait_idle();
    do @(posedge clk);
    while (src_words.size() != 0 || in_tvalid || pix_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random bitmap; wide_sat forces a full-width row that saturates x
  task automatic rand_phase(input bit wide_sat, output int unsigned n_src);
    logic [2:0]  depth;
    logic [1:0]  flags;
    logic [15:0] data;
    int unsigned ox, oy, w, h, ofs, stride, bpp, ppb, ub, rowskip, need, per_row;
    int unsigned total, i;
    bit          big;
    // realign counters: zero width, one row, one-byte stride ends the row at once
    if (col_cnt != 0 || row_cnt != 0 || byte_cnt != 0) begin
      apply_cfg(cfg_depth, cfg_flags, cfg_ox, cfg_oy, 0, 1, cfg_ofs, 1);
      push_src(16'($urandom), 1'b0);
      wait_idle();
    end
    depth = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(DC_1BPP, DC_16BPP))
                                       : 3'($urandom_range(DC_16BPP + 1, DC_WIDE_MAX));
    big   = wide_sat || ($urandom_range(0, 11) == 0);
    if (big) depth = DC_1BPP;
    flags = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: ox = 0;
      1: ox = 1023;
      default: ox = $urandom_range(0, 1023);
    endcase
    case ($urandom_range(0, 5))
      0: oy = 0;
      1: oy = 1023;
      default: oy = $urandom_range(0, 1023);
    endcase
    if (big) begin
      w = $urandom_range(200, 1024);
      h = 1;
    end else begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = 1024;
        default: h = $urandom_range(1, 4);
      endcase
    end
    ofs = $urandom_range(0, 7);
    if (wide_sat) begin
      ox  = 1023;
      oy  = 1023;
      w   = 1024;
      ofs = 7;
    end
    bpp     = (depth > DC_16BPP) ? 16 : (1 << depth);
    ppb     = (bpp < 16) ? 8 / bpp : 1;
    ub      = (bpp == 16) ? 2 : 1;
    rowskip = ofs & (ppb - 1);
    need    = (w == 0) ? 0 : (rowskip + w + ppb - 1) / ppb;
    if (w == 0)
      stride = $urandom_range(1, 6);
    else if (!wide_sat && $urandom_range(0, 5) == 0)
      stride = $urandom_range(1, need * ub);
    else
      stride = need * ub + (wide_sat ? 0 : $urandom_range(0, 4));
    per_row = (need > (stride + ub - 1) / ub) ? need : (stride + ub - 1) / ub;
    total   = ((h == 0) ? 1 : h) * per_row;
    // tall bitmaps are cut short; a few others are truncated or overrun
    if (h == 1024)
      total = $urandom_range(1, 2 * per_row);
    else if (!wide_sat && $urandom_range(0, 5) == 0)
      total = $urandom_range(0, 1) ? $urandom_range(1, total) : total + $urandom_range(1, 5);
    apply_cfg(depth, flags, ox, oy, w, h, ofs, stride);
    for (i = 0; i < total; i++) begin
      if ($urandom_range(0, 9) == 0) push_pal(8'($urandom), 16'($urandom));
      case ($urandom_range(0, 7))
        0: data = 16'h0000;
        1: data = 16'hffff;
        default: data = 16'($urandom);
      endcase
      push_src(data, (wide_sat && i == total / 2) || $urandom_range(0, 39) == 0);
    end
    n_src = total;
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned n_src, src_total, s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // load every palette entry so later lookups are defined
    for (s = 0; s < 256; s++) push_pal(s[7:0], 16'($urandom));
    wait_idle();

    // reset config: 1 bpp through palette, single pixel bitmap
    push_src(16'hff80, 1'b0);
    push_src(16'h0000, 1'b0);
    wait_idle();

    // 16 bpp transparent at the far corner, last pixel transparent
    apply_cfg(DC_16BPP, DRAW_TRANSP, 1023, 1023, 3, 2, 0, 6);
    push_src(16'h0000, 1'b0);
    push_src(16'hffff, 1'b0);
    push_src(16'h1234, 1'b0);
    push_src(16'h8000, 1'b0);
    push_src(16'h0001, 1'b0);
    push_src(16'h0000, 1'b0);
    wait_idle();

    // 4 bpp palette with row skip and a padding byte, palette write mid-row
    apply_cfg(DC_4BPP, DRAW_PALETTE, 0, 0, 3, 1, 5, 3);
    push_src(16'h00ab, 1'b0);
    push_pal(8'hff, 16'hffff);
    push_src(16'hffcd, 1'b0);
    push_src(16'h12ef, 1'b0);
    wait_idle();

    // depth code past 16 bpp, stride shorter than the width
    apply_cfg(DC_WIDE_MAX, DRAW_TRANSP | DRAW_PALETTE, 5, 9, 2, 1, 0, 1);
    push_src(16'h5555, 1'b0);
    push_src(16'haaaa, 1'b0);
    wait_idle();

    // zero width and zero height: rows draw nothing
    apply_cfg(DC_2BPP, DRAW_TRANSP | DRAW_PALETTE, 17, 33, 0, 0, 3, 1);
    push_src(16'h1111, 1'b0);
    push_src(16'h2222, 1'b0);
    wait_idle();

    // 8 bpp raw, stride 2048 and height 1024, row left open
    apply_cfg(DC_8BPP, 2'b00, 100, 200, 2, 1024, 0, 2048);
    push_src(16'h00ff, 1'b0);
    push_src(16'hff00, 1'b0);
    push_src(16'h7f80, 1'b0);
    wait_idle();

    rand_phase(1'b1, n_src);
    src_total = n_src;
    while (src_total < RAND_ITEMS) begin
      rand_phase(1'b0, n_src);
      src_total += n_src;
    end

    wait_idle();
    if (fail_cnt == 0 && pix_expect.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

endmodule
